>>> design/circular_list_engine_defines.svh
// Assertion macros shared by the checker of the circular list engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CIRCULAR_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular list engine: property violated");

// Next-cycle implication, disabled during reset.
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular list engine: property violated");

`endif

>>> design/cle_pkg.sv
// Package of the circular list engine: command and status codes, field widths,
// control state and cell operation types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int CMD_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD_HEAD  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_AFTER = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SUM       = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

endpackage

`default_nettype wire

>>> design/cle_if.sv
// Valid/ready channel interfaces of the circular list engine: command and result.
// Depends on cle_pkg for the command and status widths.
`timescale 1ns / 1ps
`default_nettype none

interface cle_req_if #(
  parameter int DATA_WIDTH = 32
);
  import cle_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             cmd;
  logic signed [DATA_WIDTH-1:0] new_value;
  logic signed [DATA_WIDTH-1:0] match_key;

  modport source (output valid, output cmd, output new_value, output match_key,
                  input ready);
  modport sink (input valid, input cmd, input new_value, input match_key,
                output ready);
endinterface

interface cle_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int COUNT_W    = 5
);
  import cle_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic signed [DATA_WIDTH-1:0] item_value;
  logic [COUNT_W-1:0]           entry_count;
  logic signed [DATA_WIDTH-1:0] total_sum;
  logic                         last;

  modport source (output valid, output status, output item_value, output entry_count,
                  output total_sum, output last, input ready);
  modport sink (input valid, input status, input item_value, input entry_count,
                input total_sum, input last, output ready);
endinterface

`default_nettype wire

>>> design/cle_cell.sv
// One storage cell of the list ring: holds the entry at a fixed position and
// takes a neighbor's value to rotate, open a gap or close one. Depends on cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cle_pkg::cell_op_t     op,
  input  logic [CNT_W-1:0]      pos,
  input  logic [CNT_W-1:0]      tail,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic [DATA_WIDTH-1:0] prev_value,
  input  logic [DATA_WIDTH-1:0] next_value,
  input  logic [DATA_WIDTH-1:0] head_value,
  output logic [DATA_WIDTH-1:0] value
);
  import cle_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (op)
      OP_ROTATE: begin
        if (IDX == tail) begin
          value_next = head_value;
        end else if (IDX < tail) begin
          value_next = next_value;
        end
      end
      OP_INSERT: begin
        if (IDX == pos) begin
          value_next = new_value;
        end else if (IDX > pos) begin
          value_next = prev_value;
        end
      end
      OP_DELETE: begin
        if (IDX >= pos) begin
          value_next = next_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

>>> design/circular_list_engine.sv
// Top level of the circular list engine: command decode, ring of storage cells,
// scan control and result register. Depends on cle_pkg, cle_if and cle_cell.
//
//   Channel  Modport  Beat
//   req      sink     cmd, new_value, match_key
//   rsp      source   status, item_value, entry_count, total_sum, last
//
// Add head, add tail, deletes of head or tail, count and unused codes go straight to the finish state.
// Add after key, delete by key, search and sum on N entries first scan all N of them:
// the ring rotates one entry past the head cell per cycle and comes back in order.
// A dump of N entries gives N beats, one per cycle while the result beat is not stalled.
// Reset clears the entry count and the control state; entry values stay undefined.
// A stalled result beat holds the engine before it writes its next result.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  cle_req_if.sink   req,
  cle_rsp_if.source rsp
);
  import cle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t                state;
  state_t                state_next;
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      occ_next;
  logic [CMD_W-1:0]      cmd_r;
  logic [DATA_WIDTH-1:0] nv_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]      idx;
  logic                  found;
  logic [CNT_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] sum_r;

  logic                  out_valid;
  logic [STATUS_W-1:0]   status_r;
  logic [DATA_WIDTH-1:0] item_r;
  logic [CNT_W-1:0]      count_r;
  logic [DATA_WIDTH-1:0] sum_out;
  logic                  last_r;

  logic                  accept;
  logic                  scan_needed;
  logic                  scan_end;
  logic                  scan_step;
  logic                  out_free;
  logic                  out_load;
  logic                  is_empty;
  logic                  is_full;
  logic [STATUS_W-1:0]   ld_status;
  logic [DATA_WIDTH-1:0] ld_item;
  logic [DATA_WIDTH-1:0] ld_sum;
  logic                  ld_last;
  cell_op_t              cell_op;
  logic [CNT_W-1:0]      op_pos;
  logic [CNT_W-1:0]      tail;

  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && (state == S_IDLE);
  assign is_empty    = (occupancy == '0);
  assign is_full     = (occupancy == CNT_W'(CAPACITY));
  assign tail        = occupancy - CNT_W'(1);
  assign scan_end    = (idx == tail);
  assign out_free    = !out_valid || rsp.ready;
  assign scan_needed = !is_empty && (req.cmd == CMD_ADD_AFTER || req.cmd == CMD_DEL_KEY ||
                                     req.cmd == CMD_SEARCH || req.cmd == CMD_SUM ||
                                     req.cmd == CMD_DUMP);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cle_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (op_pos),
      .tail      (tail),
      .new_value (nv_r),
      .prev_value(cell_val[(i == 0) ? i : i - 1]),
      .next_value(cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .head_value(cell_val[0]),
      .value     (cell_val[i])
    );
  end

  always_comb begin
    state_next = state;
    occ_next   = occupancy;
    cell_op    = OP_HOLD;
    op_pos     = '0;
    scan_step  = 1'b0;
    out_load   = 1'b0;
    ld_status  = ST_OK;
    ld_item    = '0;
    ld_sum     = '0;
    ld_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = scan_needed ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (cmd_r != CMD_DUMP || out_free) begin
          scan_step = 1'b1;
          cell_op   = OP_ROTATE;
          if (cmd_r == CMD_DUMP) begin
            out_load = 1'b1;
            ld_item  = cell_val[0];
            ld_last  = scan_end;
          end
          if (scan_end) begin
            state_next = (cmd_r == CMD_DUMP) ? S_IDLE : S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_r)
            CMD_ADD_HEAD, CMD_ADD_TAIL: begin
              if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                cell_op  = OP_INSERT;
                op_pos   = (cmd_r == CMD_ADD_HEAD) ? '0 : occupancy;
                occ_next = occupancy + CNT_W'(1);
              end
            end
            CMD_ADD_AFTER: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end else if (!found) begin
                ld_status = ST_NOTFOUND;
              end else if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                cell_op  = OP_INSERT;
                op_pos   = pos + CNT_W'(1);
                occ_next = occupancy + CNT_W'(1);
              end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end else begin
                cell_op  = OP_DELETE;
                op_pos   = (cmd_r == CMD_DEL_HEAD) ? '0 : tail;
                occ_next = tail;
              end
            end
            CMD_DEL_KEY: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end else if (!found) begin
                ld_status = ST_NOTFOUND;
              end else begin
                cell_op  = OP_DELETE;
                op_pos   = pos;
                occ_next = tail;
              end
            end
            CMD_SEARCH: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end else if (!found) begin
                ld_status = ST_NOTFOUND;
              end
            end
            CMD_COUNT, CMD_DUMP: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end
            end
            CMD_SUM: begin
              if (is_empty) begin
                ld_status = ST_EMPTY;
              end else begin
                ld_sum = sum_r;
              end
            end
            default: ld_status = ST_OK;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occ_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= req.cmd;
      nv_r  <= req.new_value;
      key_r <= req.match_key;
      idx   <= '0;
      found <= 1'b0;
      pos   <= '0;
      sum_r <= '0;
    end else if (scan_step) begin
      idx   <= idx + CNT_W'(1);
      sum_r <= sum_r + cell_val[0];
      if (!found && cell_val[0] == key_r) begin
        found <= 1'b1;
        pos   <= idx;
      end
    end
    if (out_load) begin
      status_r <= ld_status;
      item_r   <= ld_item;
      count_r  <= occ_next;
      sum_out  <= ld_sum;
      last_r   <= ld_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = status_r;
  assign rsp.item_value  = item_r;
  assign rsp.entry_count = count_r;
  assign rsp.total_sum   = sum_out;
  assign rsp.last        = last_r;

endmodule

`default_nettype wire

>>> design/cle_checker.sv
// Port-level checker of the circular list engine and its bind to the top level.
// Depends on cle_pkg and on the macros in circular_list_engine_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_list_engine_defines.svh"

module cle_checker #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [cle_pkg::STATUS_W-1:0]     rsp_status,
  input logic [DATA_WIDTH-1:0]            rsp_item_value,
  input logic [$clog2(CAPACITY + 1)-1:0]  rsp_entry_count,
  input logic [DATA_WIDTH-1:0]            rsp_total_sum,
  input logic                             rsp_last
);
  import cle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  `CLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_item_value) && $stable(rsp_last))
  `CLE_ASSERT_IMPLY(a_count_bound, rsp_valid, rsp_entry_count <= CNT_W'(CAPACITY))
  `CLE_ASSERT_IMPLY(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_entry_count == CNT_W'(CAPACITY) && rsp_last)
  `CLE_ASSERT_IMPLY(a_empty_beat, rsp_valid && rsp_status == ST_EMPTY, rsp_entry_count == '0 && rsp_last && rsp_item_value == '0 && rsp_total_sum == '0)
  `CLE_ASSERT_IMPLY(a_sum_or_item, rsp_valid && rsp_total_sum != '0, rsp_item_value == '0 && rsp_last && rsp_status == ST_OK)

endmodule

bind circular_list_engine cle_checker #(
  .CAPACITY  (CAPACITY),
  .DATA_WIDTH(DATA_WIDTH)
) u_cle_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_item_value (rsp.item_value),
  .rsp_entry_count(rsp.entry_count),
  .rsp_total_sum  (rsp.total_sum),
  .rsp_last       (rsp.last)
);

`default_nettype wire
